// ===== hw/rtl/sitrd_pkg.sv =====
// shared constants for the signed integer to radix digits core
`timescale 1ns / 1ps

package sitrd_pkg;

   localparam int MAX_BASE  = 32;
   localparam int SYM_SLOTS = 32;
   localparam int SYM_W     = 8;
   localparam int NUM_W     = 32;
   localparam int LEN_W     = 6;
   localparam int DIG_W     = $clog2(SYM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int SYM_PER_REG = CSR_DAT_W / SYM_W;

   localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_0_7   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_8_15  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_16_23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_24_31 = 3'd4;

   typedef logic [SYM_SLOTS-1:0][SYM_W-1:0] sym_bank_type;
   typedef logic [SYM_SLOTS-1:0][DIG_W-1:0] dig_stack_type;

endpackage

// ===== hw/rtl/signed_integer_to_radix_digits_core.sv =====
// signed 32-bit integer to text in a configurable radix, one character per word
`timescale 1ns / 1ps

// Converts one signed number per start into its text: a minus sign for negative
// values, then the digits of the magnitude, most significant first, one word per
// strobe, with last on the final character. The alphabet (length and up to 32
// symbols) is checked first, one symbol per cycle against all later symbols; an
// invalid alphabet gives no words. Each digit then comes from a bit-serial
// restoring divider, after which the digits are popped from a stack one per cycle.
// The last word appears in the same cycle in which busy falls, and a new start is
// taken at the first edge with busy low. The receiver cannot stall; csr writes are
// always ready but belong to idle periods.

module signed_integer_to_radix_digits_core
   import sitrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_W-1:0]     req_number,
   output logic                 rsp_strobe,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [LEN_W-1:0]      base_ff, base_in;
   sym_bank_type          sym_ff, sym_in;
   sym_bank_type          chk_ff, chk_in;
   logic [SYM_SLOTS-1:0]  mask_ff, mask_in;
   logic                  neg_ff, neg_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [DIG_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [LEN_W-1:0]      nd_ff, nd_in;
   dig_stack_type         stack_ff, stack_in;
   logic                  strobe_ff, strobe_in;
   logic [SYM_W-1:0]      symbol_ff, symbol_in;
   logic                  last_ff, last_in;

   logic                  dup;
   logic                  bad_head;
   logic [LEN_W-1:0]      trial;
   logic [LEN_W-1:0]      diff;
   logic                  qbit;

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last   = last_ff;

   // csr writes
   always_comb begin
      base_in = base_ff;
      sym_in  = sym_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_LEN: base_in = csr_data[LEN_W-1:0];
            CSR_SYMBOLS_0_7, CSR_SYMBOLS_8_15, CSR_SYMBOLS_16_23, CSR_SYMBOLS_24_31: begin
               for (int k = 0; k < SYM_PER_REG; k++) begin
                  sym_in[DIG_W'((int'(csr_index) - 1) * SYM_PER_REG + k)] =
                     csr_data[k*SYM_W +: SYM_W];
               end
            end
            default: ;
         endcase
      end
   end

   // head symbol against all later symbols in the alphabet
   always_comb begin
      dup = 1'b0;
      for (int k = 1; k < SYM_SLOTS; k++) begin
         if (mask_ff[k] && (chk_ff[k] == chk_ff[0])) dup = 1'b1;
      end
      bad_head = (chk_ff[0] == CH_MINUS) || (chk_ff[0] == CH_PLUS) ||
                 (chk_ff[0] <= CH_SPACE) || chk_ff[0][SYM_W-1];
   end

   // one restoring division step
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - base_ff;
      qbit  = (trial >= base_ff);
   end

   always_comb begin
      state_in  = state_ff;
      chk_in    = chk_ff;
      mask_in   = mask_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      nd_in     = nd_ff;
      stack_in  = stack_ff;
      strobe_in = 1'b0;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               chk_in = sym_ff;
               for (int k = 0; k < SYM_SLOTS; k++) begin
                  mask_in[k] = (LEN_W'(k) < base_ff);
               end
               neg_in = req_number[NUM_W-1];
               quo_in = req_number[NUM_W-1] ? (NUM_W'(0) - req_number) : req_number;
               rem_in = '0;
               cnt_in = '0;
               nd_in  = '0;
               if ((base_ff >= LEN_W'(2)) && (base_ff <= LEN_W'(MAX_BASE))) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!mask_ff[0]) begin
               state_in = ST_DIVIDE;
            end else if (bad_head || dup) begin
               state_in = ST_IDLE;
            end else begin
               chk_in  = {{SYM_W{1'b0}}, chk_ff[SYM_SLOTS-1:1]};
               mask_in = {1'b0, mask_ff[SYM_SLOTS-1:1]};
            end
         end
         ST_DIVIDE: begin
            rem_in = qbit ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               stack_in = {stack_ff[SYM_SLOTS-2:0], rem_in};
               nd_in    = nd_ff + LEN_W'(1);
               rem_in   = '0;
               if ((quo_in == '0) || (nd_ff >= LEN_W'(SYM_SLOTS - 1))) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            symbol_in = CH_MINUS;
            last_in   = 1'b0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            symbol_in = sym_ff[stack_ff[0]];
            last_in   = (nd_ff == LEN_W'(1));
            stack_in  = {{DIG_W{1'b0}}, stack_ff[SYM_SLOTS-1:1]};
            nd_in     = nd_ff - LEN_W'(1);
            if (nd_ff == LEN_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         base_ff   <= '0;
         sym_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         sym_ff    <= sym_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff    <= chk_in;
      mask_ff   <= mask_in;
      neg_ff    <= neg_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      nd_ff     <= nd_in;
      stack_ff  <= stack_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
   end

endmodule
